// File: src/uriqp_pkg.sv
// ----------------------------------------------------------------------------
// uriqp_pkg
// Shared types, character codes and decode helpers for the URI percent
// and quoted-printable decoder.
// ----------------------------------------------------------------------------
package uriqp_pkg;

    // result slots per item and depth of the result queue
    localparam int NRES   = 3;
    localparam int QDEPTH = 4;

    // decide actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_EMIT = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // end kinds on a final result
    localparam logic END_DELIM   = 1'b0;
    localparam logic END_EXHAUST = 1'b1;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam logic [3:0] HEX_ALPHA = 4'd9;

    // one result item
    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       is_final;
        logic       end_kind;
    } res_t;

    // results handed from the decode stage to the result queue
    typedef struct packed {
        logic [1:0]           cnt;
        res_t [NRES-1:0]      res;
    } push_t;

    // outcome of deciding on one byte
    typedef struct packed {
        logic [1:0] act;
        logic [7:0] emit;
        logic [1:0] used;
        logic       past;
    } decide_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF_HEX) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    // valid only for hex digits: letters carry bit 6
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        return c[3:0] + (c[6] ? HEX_ALPHA : 4'd0);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) ? c + CASE_GAP : c;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SPACE ||
               c == CH_SQUOTE || c == CH_DQUOTE || c == CH_LT || c == CH_GT ||
               c == CH_LPAREN || c == CH_RPAREN;
    endfunction

    // decide on c with b1, b2 as lookahead; avail counts c and known lookahead
    function automatic decide_t decide(input logic [7:0] c, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [1:0] avail,
                                       input logic past);
        decide_t d;
        logic    esc;
        d.act  = ACT_EMIT;
        d.emit = to_lower(c);
        d.used = 2'd1;
        d.past = past;
        esc = (c == CH_PCT || (!past && c == CH_EQ)) && avail == 2'd3 &&
              is_hex(b1) && is_hex(b2);
        if (esc) begin
            d.emit = to_lower({hex_nibble(b1), hex_nibble(b2)});
        end
        else begin
            if (c == CH_QMARK || c == CH_SLASH || c == CH_BSLASH)
                d.past = 1'b1;
            if (avail >= 2'd2 && c == CH_EQ && b1 == CH_LF) begin
                d.act  = ACT_NONE;
                d.used = 2'd2;
            end
            else if (avail == 2'd3 && c == CH_EQ && b1 == CH_CR && b2 == CH_LF) begin
                d.act  = ACT_NONE;
                d.used = 2'd3;
            end
            else if (is_delim(c)) begin
                d.act = ACT_STOP;
            end
        end
        if (esc)
            d.used = 2'd3;
        return d;
    endfunction

endpackage

// File: src/uriqp_in_if.sv
// ----------------------------------------------------------------------------
// uriqp_in_if
// Byte channel into the decoder: one raw URI byte and a last mark per item.
// ----------------------------------------------------------------------------
interface uriqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: src/uriqp_out_if.sv
// ----------------------------------------------------------------------------
// uriqp_out_if
// Result channel out of the decoder: one decoded character or end marker.
// ----------------------------------------------------------------------------
interface uriqp_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       is_final;
    logic       end_kind;

    modport source (output valid, output has_byte, output out_byte, output is_final,
                    output end_kind, input ready);
    modport sink   (input valid, input has_byte, input out_byte, input is_final,
                    input end_kind, output ready);
endinterface

// File: src/uriqp_core.sv
// ----------------------------------------------------------------------------
// uriqp_core
// Lookahead registers and decode logic. Decides on held bytes once two are held
// as an item arrives, or on a last byte, and hands zero to three results to the result queue.
// ----------------------------------------------------------------------------
module uriqp_core (
    input  logic                 clk,
    input  logic                 rst_n,
    uriqp_in_if.sink             text,
    input  logic                 space,
    output uriqp_pkg::push_t     push
);

    logic [7:0]           pend_reg [2];
    logic [7:0]           pend_next [2];
    logic [1:0]           pcnt_reg, pcnt_next;
    logic                 past_reg, past_next;
    logic                 stop_reg, stop_next;
    logic                 accept;

    logic [1:0]           n_tot;
    logic [7:0]           lb [5];
    logic [2:0]           pos [4];
    logic                 past_s [4];
    logic                 live [4];
    logic [1:0]           avail [3];
    uriqp_pkg::decide_t   dres [3];
    uriqp_pkg::res_t      fres [3];
    logic [1:0]           fcnt;
    logic                 fkind;
    uriqp_pkg::push_t     last_push;

    assign text.ready = space;
    assign accept     = text.valid && space;
    assign n_tot      = pcnt_reg + 2'd1;

    // window of held bytes plus the new one, zero padded past the end
    always_comb
    begin
        lb[0] = (pcnt_reg == 2'd0) ? text.in_byte : pend_reg[0];
        lb[1] = (pcnt_reg == 2'd1) ? text.in_byte : pend_reg[1];
        lb[2] = text.in_byte;
        lb[3] = 8'd0;
        lb[4] = 8'd0;
    end

    // chain of up to three decisions, used in full on a last byte
    always_comb
    begin
        pos[0]    = 3'd0;
        past_s[0] = past_reg;
        live[0]   = 1'b1;
        fcnt      = 2'd0;
        fkind     = uriqp_pkg::END_EXHAUST;
        for (int k = 0; k < uriqp_pkg::NRES; k++) begin
            fres[k] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            avail[k]    = n_tot - pos[k][1:0];
            dres[k]     = uriqp_pkg::decide(lb[pos[k]], lb[pos[k] + 3'd1], lb[pos[k] + 3'd2],
                                            avail[k], past_s[k]);
            pos[k+1]    = pos[k] + {1'b0, dres[k].used};
            past_s[k+1] = dres[k].past;
            live[k+1]   = live[k] && dres[k].act != uriqp_pkg::ACT_STOP &&
                          pos[k+1] < {1'b0, n_tot};
            if (live[k] && dres[k].act == uriqp_pkg::ACT_STOP)
                fkind = uriqp_pkg::END_DELIM;
            if (live[k] && dres[k].act == uriqp_pkg::ACT_EMIT) begin
                fres[fcnt] = '{has_byte: 1'b1, out_byte: dres[k].emit,
                               is_final: 1'b0, end_kind: 1'b0};
                fcnt       = fcnt + 2'd1;
            end
        end
    end

    // mark the final result of a last byte
    always_comb
    begin
        last_push.cnt = fcnt;
        for (int k = 0; k < uriqp_pkg::NRES; k++) begin
            last_push.res[k] = fres[k];
        end
        if (fcnt == 2'd0) begin
            last_push.cnt    = 2'd1;
            last_push.res[0] = '{has_byte: 1'b0, out_byte: 8'd0,
                                 is_final: 1'b1, end_kind: fkind};
        end
        else begin
            last_push.res[fcnt - 2'd1].is_final = 1'b1;
            last_push.res[fcnt - 2'd1].end_kind = fkind;
        end
    end

    // result hand-off and next state
    always_comb
    begin
        push         = '0;
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        pcnt_next    = pcnt_reg;
        past_next    = past_reg;
        stop_next    = stop_reg;
        if (accept) begin
            if (stop_reg) begin
                if (text.in_last) begin
                    pcnt_next = 2'd0;
                    past_next = 1'b0;
                    stop_next = 1'b0;
                end
            end
            else if (text.in_last) begin
                push      = last_push;
                pcnt_next = 2'd0;
                past_next = 1'b0;
            end
            else if (pcnt_reg != 2'd2) begin
                pend_next[pcnt_reg[0]] = text.in_byte;
                pcnt_next              = pcnt_reg + 2'd1;
            end
            else begin
                past_next = dres[0].past;
                unique case (dres[0].act)
                    uriqp_pkg::ACT_STOP:
                    begin
                        push.cnt    = 2'd1;
                        push.res[0] = '{has_byte: 1'b0, out_byte: 8'd0,
                                        is_final: 1'b1, end_kind: uriqp_pkg::END_DELIM};
                        pcnt_next   = 2'd0;
                        stop_next   = 1'b1;
                    end
                    uriqp_pkg::ACT_EMIT:
                    begin
                        push.cnt    = 2'd1;
                        push.res[0] = '{has_byte: 1'b1, out_byte: dres[0].emit,
                                        is_final: 1'b0, end_kind: 1'b0};
                    end
                    default:
                    begin
                        push.cnt = 2'd0;
                    end
                endcase
                if (dres[0].act != uriqp_pkg::ACT_STOP) begin
                    unique case (dres[0].used)
                        2'd1:
                        begin
                            pend_next[0] = pend_reg[1];
                            pend_next[1] = text.in_byte;
                            pcnt_next    = 2'd2;
                        end
                        2'd2:
                        begin
                            pend_next[0] = text.in_byte;
                            pcnt_next    = 2'd1;
                        end
                        default:
                        begin
                            pcnt_next = 2'd0;
                        end
                    endcase
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pcnt_reg <= 2'd0;
            past_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else begin
            pcnt_reg <= pcnt_next;
            past_reg <= past_next;
            stop_reg <= stop_next;
        end
    end

    // lookahead bytes
    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
    end

endmodule

// File: src/uriqp_rq.sv
// ----------------------------------------------------------------------------
// uriqp_rq
// Result queue: takes up to three results in a cycle, gives one per cycle while
// the channel is ready. Reports space while at most one result waits.
// ----------------------------------------------------------------------------
module uriqp_rq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uriqp_pkg::push_t     push,
    output logic                 space,
    uriqp_out_if.source          decoded
);

    localparam int CW = $clog2(uriqp_pkg::QDEPTH + 1);

    uriqp_pkg::res_t  q_reg  [uriqp_pkg::QDEPTH];
    uriqp_pkg::res_t  q_next [uriqp_pkg::QDEPTH];
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    base;
    logic             pop;

    assign space    = cnt_reg <= CW'(uriqp_pkg::QDEPTH - uriqp_pkg::NRES);
    assign pop      = decoded.valid && decoded.ready;
    assign base     = cnt_reg - {{(CW-1){1'b0}}, pop};
    assign cnt_next = base + CW'(push.cnt);

    // head of the queue drives the channel
    assign decoded.valid    = cnt_reg != '0;
    assign decoded.has_byte = q_reg[0].has_byte;
    assign decoded.out_byte = q_reg[0].out_byte;
    assign decoded.is_final = q_reg[0].is_final;
    assign decoded.end_kind = q_reg[0].end_kind;

    // shift on pop, then append new results behind the survivors
    always_comb
    begin
        for (int i = 0; i < uriqp_pkg::QDEPTH - 1; i++) begin
            q_next[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_next[uriqp_pkg::QDEPTH-1] = q_reg[uriqp_pkg::QDEPTH-1];
        for (int i = 0; i < uriqp_pkg::QDEPTH; i++) begin
            for (int k = 0; k < uriqp_pkg::NRES; k++) begin
                if (2'(k) < push.cnt && base + CW'(k) == CW'(i))
                    q_next[i] = push.res[k];
            end
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // queued results
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < uriqp_pkg::QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// File: src/uri_percent_qp_decoder_unit.sv
// ----------------------------------------------------------------------------
// uri_percent_qp_decoder_unit
// Streaming decoder for URI text after the scheme: percent and hostname
// '=' escapes, soft line break removal, lowercasing, delimiter detection.
// ----------------------------------------------------------------------------
//   channel   dir   payload                                  handshake
//   text      in    in_byte[7:0], in_last                    valid/ready
//   decoded   out   has_byte, out_byte[7:0], is_final,       valid/ready
//                   end_kind
//
// One byte is accepted per cycle while text.ready is high; its results enter the
// result queue the next cycle. A byte with in_last gives up to three results,
// which leave at one per cycle while decoded.ready is high, through a
// four-entry result queue. text.ready is high while at most one result waits.
// Reset clears the lookahead count, hostname and stop flags and the queue.
// ----------------------------------------------------------------------------
module uri_percent_qp_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    uriqp_in_if.sink      text,
    uriqp_out_if.source   decoded
);

    uriqp_pkg::push_t push;
    logic             space;

    // lookahead and decode
    uriqp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .space (space),
        .push  (push)
    );

    // result queue
    uriqp_rq u_rq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .space   (space),
        .decoded (decoded)
    );

endmodule

// File: src/uriqp_checker.sv
// ----------------------------------------------------------------------------
// uriqp_checker
// Port-level checks on the decoder's result channel and flow control.
// ----------------------------------------------------------------------------
module uriqp_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       has_byte,
    input  logic [7:0] out_byte,
    input  logic       is_final,
    input  logic       end_kind
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(has_byte) && $stable(is_final) && $stable(end_kind))
        else $error("result changed while stalled");

    // an item without a byte is always the end marker and carries a zero byte
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> is_final && out_byte == 8'd0)
        else $error("byteless result is not a clean end marker");

    // end kind is only set on the final item
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_final |-> !end_kind)
        else $error("end kind on a non-final item");

    // emitted characters are lowercased
    a_lower: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> !(out_byte >= uriqp_pkg::CH_UA &&
                                    out_byte <= uriqp_pkg::CH_UZ))
        else $error("uppercase letter emitted");

    // an empty result queue always takes input
    a_space: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result waiting");

endmodule

bind uri_percent_qp_decoder_unit uriqp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (text.ready),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .has_byte  (decoded.has_byte),
    .out_byte  (decoded.out_byte),
    .is_final  (decoded.is_final),
    .end_kind  (decoded.end_kind)
);
